// ===== sv/sdf_pkg.sv =====
package sdf_pkg;

    // input transaction
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
        logic signed [31:0] anchor_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] stiffness;
        logic        [30:0] rest_length;
        logic        [30:0] damping;
    } t_sdf_in;

    // result transaction
    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic        [30:0] stored_energy;
        logic               too_short;
    } t_sdf_out;

    // squared length is below 3 * 2^64, its root below 2^33
    localparam int SQ_W   = 66;
    localparam int ROOT_W = 33;

endpackage

// ===== sv/sdf_stream_if.sv =====
interface sdf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/spring_damper_force.sv =====
// channel  | dir | modport | payload
// i_in     | in  | sink    | sdf_pkg::t_sdf_in  (positions, velocity, k, rest length, c)
// o_out    | out | source  | sdf_pkg::t_sdf_out (force, stored energy, too_short)
//
// one transaction enters per cycle while the output is not stalled; in order, the
// stages are 1 to 3, 33 of the square root, a to d, 64 - FRAC_BITS of the divider, output
// all stages move together, gated by the output register being free or taken
// a stall freezes every stage; valid bits travel with the data
// i_rst_n (synchronous, active low) clears only the valid bits
module spring_damper_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdf_stream_if.sink   i_in,
    sdf_stream_if.source o_out
);
    localparam int MIN_LEN = ((1 << FRAC_BITS) + 999) / 1000;
    localparam int QB      = 64 - FRAC_BITS;   // quotient bits
    localparam int NW      = 96 - FRAC_BITS;   // dividend width
    localparam int DM_W    = 63 - FRAC_BITS;   // damping term width
    localparam int RW      = sdf_pkg::ROOT_W;
    localparam int SUM_W   = 66;
    localparam int ESH     = 2 * FRAC_BITS + 1;

    // side data that rides along the square root
    typedef struct packed {
        logic [2:0][31:0]     mag;
        logic [2:0]           dneg;
        logic [2:0]           vneg;
        logic [2:0][DM_W-1:0] dm;
        logic [30:0]          k;
        logic [30:0]          rq;
    } t_mid;

    // side data that rides along the divider
    typedef struct packed {
        logic [2:0]           dneg;
        logic                 sneg;
        logic [2:0]           vneg;
        logic [2:0][DM_W-1:0] dm;
        logic                 short_len;
        logic [30:0]          energy;
    } t_tail;

    // whole pipeline advances when the output register can take a result
    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage 1: differences and magnitudes
    logic                    r_v1;
    logic signed [2:0][32:0] r1_dif;
    logic [2:0][31:0]        r1_vm;
    logic [2:0]              r1_vneg;
    logic [30:0]             r1_k, r1_rq, r1_c;

    logic signed [31:0] w_p [3];
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_v [3];
    assign w_p[0] = i_in.data.pos_x;    assign w_a[0] = i_in.data.anchor_x;
    assign w_p[1] = i_in.data.pos_y;    assign w_a[1] = i_in.data.anchor_y;
    assign w_p[2] = i_in.data.pos_z;    assign w_a[2] = i_in.data.anchor_z;
    assign w_v[0] = i_in.data.vel_x;
    assign w_v[1] = i_in.data.vel_y;
    assign w_v[2] = i_in.data.vel_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_dif[i]  <= 33'(w_p[i]) - 33'(w_a[i]);
                r1_vneg[i] <= w_v[i][31];
                r1_vm[i]   <= w_v[i][31] ? 32'(-33'(w_v[i])) : 32'(w_v[i]);
            end
            r1_k  <= i_in.data.stiffness;
            r1_rq <= i_in.data.rest_length;
            r1_c  <= i_in.data.damping;
        end
    end

    // ---------------- stage 2: squares and damping products
    logic                 r_v2;
    logic [2:0][63:0]     r2_sq;
    logic [2:0][62:0]     r2_dp;
    logic [2:0][31:0]     r2_mag;
    logic [2:0]           r2_dneg, r2_vneg;
    logic [30:0]          r2_k, r2_rq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [31:0] m;
                m = r1_dif[i][32] ? 32'(-r1_dif[i]) : 32'(r1_dif[i]);
                r2_mag[i]  <= m;
                r2_sq[i]   <= 64'(m) * 64'(m);
                r2_dp[i]   <= 63'(r1_c) * 63'(r1_vm[i]);
                r2_dneg[i] <= r1_dif[i][32];
            end
            r2_vneg <= r1_vneg;
            r2_k    <= r1_k;
            r2_rq   <= r1_rq;
        end
    end

    // ---------------- stage 3: sum of squares
    logic                      r_v3;
    logic [sdf_pkg::SQ_W-1:0]  r3_sum;
    t_mid                      r3_mid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sum <= 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r3_mid.dm[i] <= DM_W'(r2_dp[i] >> FRAC_BITS);
            end
            r3_mid.mag  <= r2_mag;
            r3_mid.dneg <= r2_dneg;
            r3_mid.vneg <= r2_vneg;
            r3_mid.k    <= r2_k;
            r3_mid.rq   <= r2_rq;
        end
    end

    // ---------------- square root, one bit per stage
    logic [RW-1:0] w_len;
    t_mid          r_side [RW];
    logic          r_vs   [RW];

    sdf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r3_sum),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r3_mid;
            for (int s = 1; s < RW; s++) r_side[s] <= r_side[s-1];
        end
    end

    // ---------------- stage a: stretch and short test
    logic          r_va;
    logic [RW-1:0] ra_len;
    logic [32:0]   ra_smag;
    logic          ra_sneg;
    logic          ra_short;
    t_mid          ra_mid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic signed [34:0] st;
            st       = 35'(w_len) - 35'(r_side[RW-1].rq);
            ra_sneg  <= st[34];
            ra_smag  <= st[34] ? 33'(-st) : 33'(st);
            ra_len   <= w_len;
            ra_short <= w_len < RW'(MIN_LEN);
            ra_mid   <= r_side[RW-1];
        end
    end

    // ---------------- stage b: k * stretch and stretch squared
    logic          r_vb;
    logic [63:0]   rb_kp;
    logic [65:0]   rb_e2;
    logic [RW-1:0] rb_len;
    logic          rb_sneg, rb_short;
    t_mid          rb_mid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rb_kp    <= 64'(ra_mid.k) * 64'(ra_smag);
            rb_e2    <= 66'(ra_smag) * 66'(ra_smag);
            rb_len   <= ra_len;
            rb_sneg  <= ra_sneg;
            rb_short <= ra_short;
            rb_mid   <= ra_mid;
        end
    end

    // ---------------- stage c: partial products, split at 32 bits (stretch squared at 33 bits)
    logic             r_vc;
    logic [2:0][63:0] rc_pl, rc_ph;
    logic [63:0]      rc_el, rc_eh;
    logic [RW-1:0]    rc_len;
    logic             rc_sneg, rc_short;
    t_mid             rc_mid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                rc_pl[i] <= 64'(rb_kp[31:0])  * 64'(rb_mid.mag[i]);
                rc_ph[i] <= 64'(rb_kp[63:32]) * 64'(rb_mid.mag[i]);
            end
            rc_el    <= 64'(rb_e2[32:0])  * 64'(rb_mid.k);
            rc_eh    <= 64'(rb_e2[65:33]) * 64'(rb_mid.k);
            rc_len   <= rb_len;
            rc_sneg  <= rb_sneg;
            rc_short <= rb_short;
            rc_mid   <= rb_mid;
        end
    end

    // ---------------- stage d: dividends and energy
    logic             r_vd;
    logic [2:0][NW-1:0] rd_num;
    logic [RW-1:0]    rd_len;
    t_tail            rd_tail;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic [95:0] nsum;
            logic [96:0] esum;
            logic [96:0] esh;
            for (int i = 0; i < 3; i++) begin
                nsum      = 96'(rc_pl[i]) + {rc_ph[i], 32'd0};
                rd_num[i] <= nsum[95:FRAC_BITS];
            end
            esum = 97'(rc_el) + {rc_eh, 33'd0};
            esh  = esum >> ESH;
            // clamp energy to the largest 31-bit value
            rd_tail.energy    <= (|esh[96:31]) ? '1 : esh[30:0];
            rd_len            <= rc_len;
            rd_tail.dneg      <= rc_mid.dneg;
            rd_tail.sneg      <= rc_sneg;
            rd_tail.vneg      <= rc_mid.vneg;
            rd_tail.dm        <= rc_mid.dm;
            rd_tail.short_len <= rc_short;
        end
    end

    // ---------------- three dividers by the length
    logic [QB-1:0] w_quo [3];
    t_tail         r_tail [QB];
    logic          r_vt   [QB];

    for (genvar i = 0; i < 3; i++) begin : g_div
        sdf_div #(
            .QB (QB),
            .NW (NW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (rd_num[i]),
            .i_den (rd_len),
            .o_quo (w_quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tail[0] <= rd_tail;
            for (int s = 1; s < QB; s++) r_tail[s] <= r_tail[s-1];
        end
    end

    // ---------------- output stage: signs, sum, saturation, zero force for short springs
    sdf_pkg::t_sdf_out r_out;
    logic              r_out_v;
    t_tail             w_t;
    logic signed [31:0] w_f [3];

    assign w_t = r_tail[QB-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [SUM_W-1:0] spring, damp, tot;
            spring = SUM_W'(w_quo[i]);
            damp   = SUM_W'(w_t.dm[i]);
            if (w_t.sneg == w_t.dneg[i]) spring = -spring;
            if (!w_t.vneg[i])            damp   = -damp;
            tot = spring + damp;
            if (w_t.short_len) begin
                w_f[i] = '0;
            end else if (tot > SUM_W'(32'sh7fff_ffff)) begin
                w_f[i] = 32'sh7fff_ffff;
            end else if (tot < -SUM_W'(64'sh8000_0000)) begin
                w_f[i] = 32'sh8000_0000;
            end else begin
                w_f[i] = tot[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.force_x       <= w_f[0];
            r_out.force_y       <= w_f[1];
            r_out.force_z       <= w_f[2];
            r_out.stored_energy <= w_t.energy;
            r_out.too_short     <= w_t.short_len;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    // ---------------- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0;
            for (int s = 0; s < RW; s++) r_vs[s] <= 1'b0;
            for (int s = 0; s < QB; s++) r_vt[s] <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vs[0] <= r_v3;
            for (int s = 1; s < RW; s++) r_vs[s] <= r_vs[s-1];
            r_va <= r_vs[RW-1];
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_vt[0] <= r_vd;
            for (int s = 1; s < QB; s++) r_vt[s] <= r_vt[s-1];
            r_out_v <= r_vt[QB-1];
        end
    end

    // ---------------- checks
    // a spring too short carries no force at all
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.too_short |->
            o_out.data.force_x == 0 && o_out.data.force_y == 0 &&
            o_out.data.force_z == 0)
        else $error("short spring with nonzero force");

    // the root is never below a component magnitude
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> 33'(ra_mid.mag[0]) <= ra_len && 33'(ra_mid.mag[1]) <= ra_len &&
                 33'(ra_mid.mag[2]) <= ra_len)
        else $error("length below a component");

    // a waiting result freezes the pipeline and input
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_vt[QB-1]) && $stable(r_v1))
        else $error("pipeline moved during stall");

endmodule

// ===== sv/sdf_sqrt.sv =====
module sdf_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sdf_pkg::SQ_W-1:0]      i_rad,
    output logic [sdf_pkg::ROOT_W-1:0]    o_root
);
    localparam int RW  = sdf_pkg::ROOT_W;
    localparam int SW  = sdf_pkg::SQ_W;
    localparam int REM_W = RW + 2;

    logic [REM_W-1:0] r_rem  [RW];
    logic [RW-1:0]    r_root [RW];
    logic [SW-1:0]    r_rad  [RW];

    // one root bit per stage, digit by digit
    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [REM_W-1:0] w_rem_in;
        logic [RW-1:0]    w_root_in;
        logic [SW-1:0]    w_rad_in;
        logic [REM_W+1:0] w_rem4;
        logic [REM_W+1:0] w_trial;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        assign w_rem4  = {w_rem_in, w_rad_in[SW-1:SW-2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s] <= {w_rad_in[SW-3:0], 2'b00};
                if (w_rem4 >= w_trial) begin
                    r_rem[s]  <= REM_W'(w_rem4 - w_trial);
                    r_root[s] <= {w_root_in[RW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= REM_W'(w_rem4);
                    r_root[s] <= {w_root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== sv/sdf_div.sv =====
module sdf_div #(
    parameter int QB = 48,
    parameter int NW = 80
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NW-1:0]                 i_num,
    input  logic [sdf_pkg::ROOT_W-1:0]    i_den,
    output logic [QB-1:0]                 o_quo
);
    localparam int DW = sdf_pkg::ROOT_W;

    // remainder stays below the divisor; numerator low bits and quotient share r_nq
    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_nq  [QB];
    logic [DW-1:0] r_den [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [QB-1:0] w_nq_in;
        logic [DW-1:0] w_den_in;
        logic [DW:0]   w_rem2;

        if (s == 0) begin : g_first
            assign w_rem_in = DW'(i_num[NW-1:QB]);
            assign w_nq_in  = i_num[QB-1:0];
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
            assign w_den_in = r_den[s-1];
        end

        assign w_rem2 = {w_rem_in, w_nq_in[QB-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= w_den_in;
                if (w_rem2 >= {1'b0, w_den_in}) begin
                    r_rem[s] <= DW'(w_rem2 - {1'b0, w_den_in});
                    r_nq[s]  <= {w_nq_in[QB-2:0], 1'b1};
                end else begin
                    r_rem[s] <= DW'(w_rem2);
                    r_nq[s]  <= {w_nq_in[QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_nq[QB-1];

endmodule

// ===== tb/sdf_checker.sv =====
`timescale 1ns / 1ps

module sdf_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sdf_pkg::t_sdf_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sdf_pkg::t_sdf_out i_out_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count,
    output int                o_short_count
);

    localparam logic [63:0]  MIN_LEN  = ((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000;
    localparam logic [127:0] TERM_MAX = 128'd1 << 56;

    sdf_pkg::t_sdf_out expected_forces[$];
    int       fail_count = 0;
    int       result_count = 0;
    int       short_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = expected_forces.size();
    assign o_result_count = result_count;
    assign o_short_count  = short_count;

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact spring and damper force for one transaction
    function automatic sdf_pkg::t_sdf_out predict_force(sdf_pkg::t_sdf_in it);
        logic signed [33:0] dif [3];
        logic [32:0]        mag [3];
        logic signed [31:0] pos [3];
        logic signed [31:0] anc [3];
        logic signed [31:0] vel [3];
        logic [127:0]       sq, en, sp, quo;
        logic [63:0]        len, t, smag, sm, vm, dm;
        logic signed [63:0] stretch, spring, damp;
        logic               is_short, sp_neg;
        logic signed [31:0] frc [3];
        sdf_pkg::t_sdf_out  r;
        pos = '{it.pos_x, it.pos_y, it.pos_z};
        anc = '{it.anchor_x, it.anchor_y, it.anchor_z};
        vel = '{it.vel_x, it.vel_y, it.vel_z};
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            dif[i] = 34'(pos[i]) - 34'(anc[i]);
            mag[i] = dif[i] < 0 ? 33'(-dif[i]) : 33'(dif[i]);
            sq += 128'(mag[i]) * 128'(mag[i]);
        end
        len = '0;
        for (int b = 34; b >= 0; b--) begin
            t = len | (64'd1 << b);
            if (128'(t) * 128'(t) <= sq) len = t;
        end
        stretch = $signed(len) - $signed(64'(it.rest_length));
        smag = stretch < 0 ? 64'(-stretch) : 64'(stretch);
        en = (128'(smag) * 128'(smag) * 128'(it.stiffness)) >> (2 * FRAC_BITS + 1);
        r.stored_energy = en > 128'h7FFF_FFFF ? 31'h7FFF_FFFF : en[30:0];
        is_short = len < MIN_LEN;
        r.too_short = is_short;
        for (int i = 0; i < 3; i++) begin
            frc[i] = '0;
            if (!is_short) begin
                sp = 128'(it.stiffness) * 128'(smag) * 128'(mag[i]);
                quo = sp / (128'(len) << FRAC_BITS);
                sm = quo > TERM_MAX ? 64'(TERM_MAX) : quo[63:0];
                sp_neg = (stretch < 0) == (dif[i] < 0);
                vm = vel[i] < 0 ? 64'(-64'(vel[i])) : 64'(vel[i]);
                dm = (64'(it.damping) * vm) >> FRAC_BITS;
                spring = sp_neg ? -$signed(sm) : $signed(sm);
                damp = vel[i] < 0 ? $signed(dm) : -$signed(dm);
                frc[i] = 32'(clip32(spring + damp));
            end
        end
        r.force_x = frc[0];
        r.force_y = frc[1];
        r.force_z = frc[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h want %h", result_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        sdf_pkg::t_sdf_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) expected_forces.push_back(predict_force(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_forces.size() == 0) begin
                    $display("unexpected result transaction");
                    fail_count++;
                end else begin
                    want = expected_forces.pop_front();
                    if (i_out_data.force_x !== want.force_x)
                        report_mismatch("force_x", i_out_data.force_x, want.force_x);
                    if (i_out_data.force_y !== want.force_y)
                        report_mismatch("force_y", i_out_data.force_y, want.force_y);
                    if (i_out_data.force_z !== want.force_z)
                        report_mismatch("force_z", i_out_data.force_z, want.force_z);
                    if (i_out_data.stored_energy !== want.stored_energy)
                        report_mismatch("stored_energy", 32'(i_out_data.stored_energy),
                                        32'(want.stored_energy));
                    if (i_out_data.too_short !== want.too_short)
                        report_mismatch("too_short", 32'(i_out_data.too_short),
                                        32'(want.too_short));
                    if (want.too_short) short_count++;
                    result_count++;
                end
            end
        end
    end

endmodule

// ===== tb/tb_spring_damper_force.sv =====
`timescale 1ns / 1ps

module tb_spring_damper_force;

    localparam int FRAC_BITS  = 16;
    // pipeline depth of spring_damper_force
    localparam int LATENCY    = 41 + (64 - FRAC_BITS);
    localparam int N_RANDOM   = 1200;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 400;
    localparam int IN_W       = $bits(sdf_pkg::t_sdf_in);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sdf_stream_if #(.T(sdf_pkg::t_sdf_in))  in_if ();
    sdf_stream_if #(.T(sdf_pkg::t_sdf_out)) out_if ();

    int  fail_count, pending, result_count, short_count;
    int  cycles = 0;
    bit  quiet_phase = 0;   // no idling on either side near the end
    bit  hold_request = 0;  // asks the receiver for one long hold-off

    always #5 i_clk = ~i_clk;

    spring_damper_force #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    sdf_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_data     (in_if.data),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_data    (out_if.data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_short_count (short_count)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long stretch with ready low so the pipeline fills and backs up
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 0;
                out_if.ready <= 1'b1;
            end else if (quiet_phase) begin
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (run_left > 0) run_left--;
                else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 9);
                else run_left = $urandom_range(0, 30);
            end
        end
    end

    // offers one transaction and returns at the falling edge after acceptance
    task automatic send_item(sdf_pkg::t_sdf_in it);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic sender_gap(int n);
        in_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic sdf_pkg::t_sdf_in make_item(
                                          logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz, logic signed [31:0] ax,
                                          logic signed [31:0] ay, logic signed [31:0] az,
                                          logic signed [31:0] vx, logic signed [31:0] vy,
                                          logic signed [31:0] vz, logic [31:0] k,
                                          logic [31:0] rl, logic [31:0] c);
        sdf_pkg::t_sdf_in it;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.anchor_x = ax; it.anchor_y = ay; it.anchor_z = az;
        it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
        it.stiffness = k[30:0]; it.rest_length = rl[30:0]; it.damping = c[30:0];
        return it;
    endfunction

    // random spring: mostly physical sizes, some full range, some near the short limit
    function automatic sdf_pkg::t_sdf_in random_spring();
        sdf_pkg::t_sdf_in it;
        int      kind;
        it = sdf_pkg::t_sdf_in'(IN_W'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom}));
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // scene scale: positions within +-128, anchor near the point
            it.pos_x = $signed(24'($urandom));
            it.pos_y = $signed(24'($urandom));
            it.pos_z = $signed(24'($urandom));
            it.anchor_x = it.pos_x + $signed(22'($urandom));
            it.anchor_y = it.pos_y + $signed(22'($urandom));
            it.anchor_z = it.pos_z + $signed(22'($urandom));
            it.vel_x = $signed(22'($urandom));
            it.vel_y = $signed(22'($urandom));
            it.vel_z = $signed(22'($urandom));
            it.stiffness = 31'($urandom_range(0, 32'h0040_0000));
            it.rest_length = 31'($urandom_range(0, 32'h0030_0000));
            it.damping = 31'($urandom_range(0, 32'h0008_0000));
        end else if (kind < 8) begin
            // displacement around the short threshold
            it.anchor_x = it.pos_x - $signed(32'($urandom_range(0, 80)) - 32'sd40);
            it.anchor_y = it.pos_y - $signed(32'($urandom_range(0, 80)) - 32'sd40);
            it.anchor_z = it.pos_z - $signed(32'($urandom_range(0, 80)) - 32'sd40);
        end
        return it;
    endfunction

    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    localparam logic [31:0]        UMAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        sdf_pkg::t_sdf_in directed [$];
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero length spring, damping must be suppressed too
        directed.push_back(make_item(0, 0, 0, 0, 0, 0, ONE, -ONE, PMAX, ONE, ONE, UMAX));
        // length just under and just at the short threshold
        directed.push_back(make_item(65, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, ONE));
        directed.push_back(make_item(66, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, ONE));
        directed.push_back(make_item(0, -66, 0, 0, 0, 0, -ONE, ONE, 0, ONE, ONE, ONE));
        // unit spring at rest, stretched and compressed
        directed.push_back(make_item(ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, 0));
        directed.push_back(make_item(3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, 0));
        directed.push_back(make_item(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 2 * ONE, 5 * ONE, 0));
        // widest displacement on every axis or on two axes, both signs
        directed.push_back(make_item(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN,
                                     PMAX, PMAX, PMAX, UMAX, 0, UMAX));
        directed.push_back(make_item(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX,
                                     PMIN, PMIN, PMIN, UMAX, UMAX, UMAX));
        directed.push_back(make_item(PMAX, PMIN, 0, PMIN, PMAX, 0, PMIN, PMAX, 0, UMAX, 0, 0));
        // rest length far beyond the length, energy saturation
        directed.push_back(make_item(ONE, 0, 0, 0, 0, 0, 0, 0, 0, UMAX, UMAX, 0));
        // pure damping with extreme velocities
        directed.push_back(make_item(ONE, 0, 0, 0, 0, 0, PMIN, PMAX, -1, 0, ONE, UMAX));
        directed.push_back(make_item(0, ONE, 0, 0, 0, 0, 1, -1, PMIN, 0, ONE, 1));
        // zero stiffness and damping
        directed.push_back(make_item(ONE, ONE, ONE, -ONE, -ONE, -ONE, PMAX, PMIN, 0, 0, 0, 0));
        // tiny k: truncation toward zero on negative terms; then extreme lengths with k large or tiny
        directed.push_back(make_item(-7, 3, -5, 100, -100, 50, -3, 3, -1, 1, 0, 1));
        directed.push_back(make_item(PMAX, 0, 0, 0, 0, 0, 0, 0, 0, UMAX, 0, 0));
        directed.push_back(make_item(0, 0, PMIN, 0, 0, PMAX, 0, 0, 0, 1, UMAX, 0));
        directed.push_back(make_item(-1, -1, -1, 0, 0, 0, 0, 0, 0, UMAX, 0, UMAX));
        foreach (directed[i]) begin
            send_item(directed[i]);
            if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 9));
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 4) hold_request = 1;
            if (n == N_RANDOM / 2) begin
                // drain completely before going on
                sender_gap(0);
                while (pending != 0) @(negedge i_clk);
            end
            if (n == N_RANDOM * 7 / 8) quiet_phase = 1;
            send_item(random_spring());
            if (!quiet_phase && !hold_request && $urandom_range(0, 4) == 0)
                sender_gap($urandom_range(1, 9));
        end
        sender_gap(0);

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);

        $display("covered %0d springs (%0d short) incl. extremes, long output stall, drain",
                 result_count, short_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sdf_pkg.sv
sv/sdf_stream_if.sv
sv/sdf_sqrt.sv
sv/sdf_div.sv
sv/spring_damper_force.sv
tb/sdf_checker.sv
tb/tb_spring_damper_force.sv
